// File: hw/rtl/rmfh_pkg.sv
package rmfh_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  // Fixed field widths of the channels
  localparam int OpW     = 2;
  localparam int TaskW   = 8;
  localparam int CountW  = 8;
  localparam int StatusW = 3;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  typedef enum logic [OpW-1:0] {
    OP_LOCK   = 2'd0,
    OP_TRY    = 2'd1,
    OP_UNLOCK = 2'd2
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_BUSY     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_HANDOFF  = 3'd4,
    ST_HELD     = 3'd5,
    ST_ERROR    = 3'd6
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [TaskW-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic              owner_valid;
    logic [TaskW-1:0]  holder_task;
    logic [TaskW-1:0]  woken_task;
    logic [CountW-1:0] hold_count;
  } out_item_t;

  typedef struct packed {
    logic recursive_mode;
  } cfg_item_t;

endpackage

// File: hw/rtl/rmfh_if.sv
interface rmfh_in_if;
  import rmfh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmfh_out_if;
  import rmfh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmfh_cfg_if;
  import rmfh_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/recursive_mutex_with_fifo_handoff_top.sv
// Channel    Dir  Payload                                               Handshake
// in_chan    in   operation, task_id                                    valid/ready
// out_chan   out  status, owner_valid, holder_task, woken_task,         valid/ready
//                 hold_count
// cfg_chan   in   recursive_mode                                        valid/ready
//
// Each request runs in order: the accept edge issues the wait queue
// memory read at the head pointer; the decision edge, taken once the output
// register is free, decides with that read data and writes back owner,
// count, pointers and the queue tail entry. Reset (rst_n, synchronous,
// active low) clears the lock state and the queue pointers at once; the
// queue memory is not cleared, no clearing pass. The result waits in an
// output register; a new request is accepted while it waits, and its decision holds until the output register is free.
module recursive_mutex_with_fifo_handoff_top #(
  parameter int QUEUE_DEPTH  = rmfh_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = rmfh_pkg::TASK_ID_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rmfh_in_if.sink    in_chan,
  rmfh_out_if.source out_chan,
  rmfh_cfg_if.sink   cfg_chan
);
  import rmfh_pkg::*;

  // Only the low id bits matter: TASK_ID_BITS of them, at most the 8-bit field
  localparam int IdW   = (TASK_ID_BITS < TaskW) ? TASK_ID_BITS : TaskW;
  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);

  // Configuration
  logic rec_mode_r;

  // Lock state
  logic              has_owner_r, has_owner_nxt;
  logic [IdW-1:0]    owner_r, owner_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [PtrW-1:0]   head_r, head_nxt;
  logic [PtrW-1:0]   tail_r, tail_nxt;
  logic [FillW-1:0]  fill_r, fill_nxt;

  // Request held for the decision cycle
  logic [OpW-1:0] op_r;
  logic [IdW-1:0] who_r;

  // Wait queue memory and its registered head read
  logic [IdW-1:0] queue_mem [QUEUE_DEPTH];
  logic [IdW-1:0] head_data_r;
  logic           mem_we;

  // Sequencer
  fsm_t state_r, state_nxt;
  logic in_fire;
  logic out_free;
  logic exec_fire;

  // Output register
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  status_t           status;
  logic [IdW-1:0]    woken;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_mode_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      rec_mode_r <= cfg_chan.data.recursive_mode;
    end
  end

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_fire) state_nxt = FSM_EXEC;
      FSM_EXEC: if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_chan.ready = 1'b0;
    exec_fire     = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_chan.ready = 1'b1;
      FSM_EXEC: exec_fire = out_free;
      default:  in_chan.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request and read the queue head on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_chan.data.operation;
      who_r       <= in_chan.data.task_id[IdW-1:0];
      head_data_r <= queue_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[tail_r] <= who_r;
    end
  end

  // Decide the request against the lock state
  always_comb begin
    has_owner_nxt = has_owner_r;
    owner_nxt     = owner_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    woken         = '0;
    mem_we        = 1'b0;
    status        = ST_ERROR;

    unique case (op_r)
      OP_LOCK, OP_TRY: begin
        if (!has_owner_r) begin
          has_owner_nxt = 1'b1;
          owner_nxt     = who_r;
          count_nxt     = CountW'(1);
          status        = ST_GRANTED;
        end else if (owner_r == who_r) begin
          // Owner asks again: nest in recursive mode below COUNT_MAX, else error (self-deadlock) or busy
          if (!rec_mode_r) begin
            status = (op_r == OP_LOCK) ? ST_ERROR : ST_BUSY;
          end else if (count_r == COUNT_MAX) begin
            status = ST_ERROR;
          end else begin
            count_nxt = count_r + 1'b1;
            status    = ST_GRANTED;
          end
        end else if (op_r == OP_TRY) begin
          status = ST_BUSY;
        end else if (fill_r == FillMax) begin
          status = ST_ERROR;
        end else begin
          mem_we   = exec_fire;
          tail_nxt = next_slot(tail_r);
          fill_nxt = fill_r + 1'b1;
          status   = ST_QUEUED;
        end
      end
      OP_UNLOCK: begin
        if (!has_owner_r || owner_r != who_r) begin
          status = ST_ERROR;
        end else if (rec_mode_r && count_r > CountW'(1)) begin
          count_nxt = count_r - 1'b1;
          status    = ST_HELD;
        end else if (fill_r != '0) begin
          // Final unlock with waiters: hand the lock to the head waiter
          owner_nxt = head_data_r;
          head_nxt  = next_slot(head_r);
          fill_nxt  = fill_r - 1'b1;
          count_nxt = CountW'(1);
          woken     = head_data_r;
          status    = ST_HANDOFF;
        end else begin
          has_owner_nxt = 1'b0;
          owner_nxt     = '0;
          count_nxt     = '0;
          status        = ST_RELEASED;
        end
      end
      default: status = ST_ERROR;
    endcase

    out_nxt.status      = status;
    out_nxt.owner_valid = has_owner_nxt;
    out_nxt.holder_task = TaskW'(owner_nxt);
    out_nxt.woken_task  = TaskW'(woken);
    out_nxt.hold_count  = count_nxt;
  end

  // Write back the lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_owner_r <= 1'b0;
      owner_r     <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
    end else if (exec_fire) begin
      has_owner_r <= has_owner_nxt;
      owner_r     <= owner_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // Output register: load on decision, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule
